// ===== src/wavetable_oscillator_unit_defines.svh =====
// Assertion macros used by the wavetable oscillator top level.
`ifndef WAVETABLE_OSCILLATOR_UNIT_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is high
`define WTO_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wavetable oscillator check failed");
// Clocked check that also holds through reset
`define WTO_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wavetable oscillator check failed");
`else
`define WTO_ASSERT(lbl, clk, rst, prop)
`define WTO_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== src/wto_pkg.sv =====
// Shared constants, types and band limit table of the wavetable oscillator.
package wto_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int NUM_BANDS  = 120;

  localparam int IDX_W    = $clog2(TABLE_SIZE);
  localparam int HALF_W   = IDX_W - 1;
  localparam int PHASE_W  = 32;
  localparam int FRAC_W   = PHASE_W - IDX_W;
  localparam int BAND_W   = 7;
  localparam int WAVE_W   = 2;
  localparam int FREQ_W   = 22;
  localparam int STEP_W   = 20;
  localparam int SAMPLE_W = 24;
  localparam int SIDX_W   = 10;
  localparam int RAM_AW   = WAVE_W + BAND_W + HALF_W;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int PROD_W   = SAMPLE_W + 1 + FRAC_W + 1;

  // APB register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_PHASE_STEP = '0;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(97392);

  // Note limits in Q14.8 hertz; the series stops at the top note and repeats
  localparam int BAND_LIMITS [128] = '{
    4186, 4435, 4699, 4978, 5274, 5588, 5920, 6272, 6645, 7040, 7459, 7902,
    8372, 8870, 9397, 9956, 10548, 11175, 11840, 12544, 13290, 14080, 14917, 15804,
    16744, 17740, 18795, 19912, 21096, 22351, 23680, 25088, 26580, 28160, 29834,
    31609, 33488, 35479, 37589, 39824, 42192, 44701, 47359, 50175, 53159, 56320,
    59669, 63217, 66976, 70959, 75178, 79649, 84385, 89402, 94719, 100351, 106318,
    112640, 119338, 126434, 133952, 141917, 150356, 159297, 168769, 178805, 189437,
    200702, 212636, 225280, 238676, 252868, 267905, 283835, 300713, 318594, 337539,
    357610, 378874, 401403, 425272, 450560, 477352, 505736, 535809, 567670, 601425,
    637188, 675077, 715219, 757749, 802807, 850544, 901120, 954703, 1011473,
    1071618, 1135340, 1202851, 1274376, 1350155, 1430439, 1515497, 1605613,
    1701088, 1802240, 1909407, 2022946, 2143237, 2270680, 2405702, 2548752,
    2700309, 2860878, 3030994, 3211227, 3402176,
    3402176, 3402176, 3402176, 3402176, 3402176, 3402176, 3402176, 3402176,
    3402176, 3402176, 3402176
  };

  localparam logic [FREQ_W-1:0] TOP_LIMIT = FREQ_W'(BAND_LIMITS[NUM_BANDS-1]);

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_WRITE     = 2'd1,
    OP_SET_PHASE = 2'd2,
    OP_IDLE      = 2'd3
  } op_t;

  // Decoded transaction held in the first stage
  typedef struct packed {
    op_t                       op;
    logic [WAVE_W-1:0]         wave;
    logic [BAND_W-1:0]         band;
    logic                      above;
    logic [PHASE_W-1:0]        inc;
    logic [BAND_W-1:0]         band_index;
    logic [SIDX_W-1:0]         sample_index;
    logic signed [SAMPLE_W-1:0] table_value;
    logic [PHASE_W-1:0]        phase_value;
  } front_t;

  // Per-transaction control carried down the interpolation stages
  typedef struct packed {
    logic               live;
    logic               above;
    logic [PHASE_W-1:0] phase_now;
  } ctl_t;

endpackage

// ===== src/wto_front.sv =====
// Input decode: band search, range check and phase increment product.
module wto_front import wto_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic [1:0]                 operation,
  input  logic [WAVE_W-1:0]          waveform,
  input  logic [FREQ_W-1:0]          frequency,
  input  logic [BAND_W-1:0]          band_index,
  input  logic [SIDX_W-1:0]          sample_index,
  input  logic signed [SAMPLE_W-1:0] table_value,
  input  logic [PHASE_W-1:0]         phase_value,
  input  logic [STEP_W-1:0]          phase_step,
  output front_t                     s1
);

  logic [BAND_W-1:0]        band_sel;
  logic [FREQ_W+STEP_W-1:0] prod;

  // Pick the lowest band whose limit is at or above the frequency
  always_comb begin
    band_sel = '0;
    for (int i = NUM_BANDS - 2; i >= 0; i--) begin
      if (FREQ_W'(BAND_LIMITS[i]) >= frequency) begin
        band_sel = BAND_W'(i);
      end
    end
  end

  // Phase increment, frequency in Q8 times step per hertz
  assign prod = {{STEP_W{1'b0}}, frequency} * {{FREQ_W{1'b0}}, phase_step};

  // Hold the decoded transaction
  always_ff @(posedge clk) begin
    if (en) begin
      s1.op           <= op_t'(operation);
      s1.wave         <= waveform;
      s1.band         <= band_sel;
      s1.above        <= (frequency > TOP_LIMIT);
      s1.inc          <= prod[PHASE_W+7:8];
      s1.band_index   <= band_index;
      s1.sample_index <= sample_index;
      s1.table_value  <= table_value;
      s1.phase_value  <= phase_value;
    end
  end

endmodule

// ===== src/wto_table.sv =====
// Wave table store split into even and odd banks so both neighbours read at once.
module wto_table import wto_pkg::*; (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_idx,
  input  logic [WAVE_W-1:0]          rd_wave,
  input  logic [BAND_W-1:0]          rd_band,
  input  logic                       wr_en,
  input  logic [WAVE_W-1:0]          wr_wave,
  input  logic [BAND_W-1:0]          wr_band,
  input  logic [IDX_W-1:0]           wr_idx,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  output logic signed [SAMPLE_W-1:0] v0,
  output logic signed [SAMPLE_W-1:0] v1
);

  logic [SAMPLE_W-1:0] even_mem [RAM_DEPTH];
  logic [SAMPLE_W-1:0] odd_mem  [RAM_DEPTH];

  logic [HALF_W-1:0]   even_half;
  logic [RAM_AW-1:0]   even_addr;
  logic [RAM_AW-1:0]   odd_addr;
  logic [RAM_AW-1:0]   wr_addr;
  logic [SAMPLE_W-1:0] even_q;
  logic [SAMPLE_W-1:0] odd_q;
  logic                odd_sel;

  // Odd first word: the even neighbour sits one pair on, wrapping at the end
  assign even_half = rd_idx[0] ? rd_idx[IDX_W-1:1] + HALF_W'(1) : rd_idx[IDX_W-1:1];
  assign even_addr = {rd_wave, rd_band, even_half};
  assign odd_addr  = {rd_wave, rd_band, rd_idx[IDX_W-1:1]};
  assign wr_addr   = {wr_wave, wr_band, wr_idx[IDX_W-1:1]};

  // Even bank
  always_ff @(posedge clk) begin
    if (wr_en && !wr_idx[0]) begin
      even_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      even_q <= even_mem[even_addr];
    end
  end

  // Odd bank
  always_ff @(posedge clk) begin
    if (wr_en && wr_idx[0]) begin
      odd_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      odd_q <= odd_mem[odd_addr];
    end
  end

  // Remember which bank holds the first word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      odd_sel <= rd_idx[0];
    end
  end

  assign v0 = odd_sel ? odd_q : even_q;
  assign v1 = odd_sel ? even_q : odd_q;

endmodule

// ===== src/wto_interp.sv =====
// Linear interpolation pipeline: difference, product, sum and result register.
module wto_interp import wto_pkg::*; (
  input  logic                       clk,
  input  logic                       en3,
  input  logic                       en4,
  input  logic                       en_out,
  input  logic signed [SAMPLE_W-1:0] v0,
  input  logic signed [SAMPLE_W-1:0] v1,
  input  logic [FRAC_W-1:0]          frac2,
  input  ctl_t                       ctl2,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       above_range,
  output logic [PHASE_W-1:0]         phase_now
);

  logic signed [SAMPLE_W:0]   d3;
  logic signed [SAMPLE_W-1:0] v0_3;
  logic [FRAC_W-1:0]          frac3;
  ctl_t                       ctl3;

  logic signed [PROD_W-1:0]   prod4;
  logic signed [SAMPLE_W-1:0] v0_4;
  ctl_t                       ctl4;

  logic signed [PROD_W-1:0]   step;
  logic signed [SAMPLE_W-1:0] interp;

  // Take the difference of the two neighbours
  always_ff @(posedge clk) begin
    if (en3) begin
      d3    <= {v1[SAMPLE_W-1], v1} - {v0[SAMPLE_W-1], v0};
      v0_3  <= v0;
      frac3 <= frac2;
      ctl3  <= ctl2;
    end
  end

  // Scale the difference by the phase fraction
  always_ff @(posedge clk) begin
    if (en4) begin
      prod4 <= d3 * $signed({1'b0, frac3});
      v0_4  <= v0_3;
      ctl4  <= ctl3;
    end
  end

  // Arithmetic shift floors toward minus infinity
  assign step   = prod4 >>> FRAC_W;
  assign interp = v0_4 + step[SAMPLE_W-1:0];

  // Result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (en_out) begin
      sample_out  <= ctl4.live ? interp : '0;
      above_range <= ctl4.above;
      phase_now   <= ctl4.phase_now;
    end
  end

endmodule

// ===== src/wavetable_oscillator_unit.sv =====
// Band-limited wavetable oscillator, top level.
// Input channel item_valid/item_stall carries one transaction per accepted item:
//   next sample, write one table word, set the phase or idle (operation field).
// Output channel result_valid/result_stall returns exactly one result per item
//   (sample_out, above_range, phase_now), in order.
// An item goes through decode, table read, difference, product and result registers.
// Throughput: one item per cycle while item_stall is low; set by the phase add and
//   by the two table banks, each giving one read per cycle to fetch both
//   neighbouring words together.
// When the receiver stalls, the result register holds and the pipeline keeps
//   filling its empty stages; item_stall rises only once every stage is full.
// Reset (rst, synchronous) empties the pipeline, clears the phase to zero and
//   restores phase_step_per_hz to its default. Table contents are not cleared:
//   software must load every word it will read before asking for samples (not enforced).
// The APB port holds phase_step_per_hz at byte address 0; pready is always high.
// Write the register only while no transaction is in flight.
`include "wavetable_oscillator_unit_defines.svh"
module wavetable_oscillator_unit import wto_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 operation,
  input  logic [WAVE_W-1:0]          waveform,
  input  logic [FREQ_W-1:0]          frequency,
  input  logic [BAND_W-1:0]          band_index,
  input  logic [SIDX_W-1:0]          sample_index,
  input  logic signed [SAMPLE_W-1:0] table_value,
  input  logic [PHASE_W-1:0]         phase_value,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       above_range,
  output logic [PHASE_W-1:0]         phase_now,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [STEP_W-1:0]  phase_step;
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_acc_next;

  front_t             s1;
  ctl_t               ctl2;
  logic [FRAC_W-1:0]  frac2;
  logic               v1, v2, v3, v4;
  logic               en1, en2, en3, en4, en_out;
  logic               adv1, live1;
  logic               rd_en, wr_en;
  logic               band_ok, samp_ok;
  logic signed [SAMPLE_W-1:0] tv0, tv1;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_PHASE_STEP) begin
      phase_step <= pwdata[STEP_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1:2] == REG_PHASE_STEP) ?
                  DATA_W'(phase_step) : '0;

  // Stage enables: a stage loads when it is empty or its successor moves
  assign en_out     = !result_valid || !result_stall;
  assign en4        = !v4 || en_out;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1)    v1           <= item_valid;
      if (en2)    v2           <= v1;
      if (en3)    v3           <= v2;
      if (en4)    v4           <= v3;
      if (en_out) result_valid <= v4;
    end
  end

  wto_front u_front (
    .clk          (clk),
    .en           (en1),
    .operation    (operation),
    .waveform     (waveform),
    .frequency    (frequency),
    .band_index   (band_index),
    .sample_index (sample_index),
    .table_value  (table_value),
    .phase_value  (phase_value),
    .phase_step   (phase_step),
    .s1           (s1)
  );

  // Phase read-modify-write as the transaction leaves the first stage
  assign adv1  = en2 && v1;
  assign live1 = (s1.op == OP_SAMPLE) && !s1.above;

  always_comb begin
    phase_acc_next = phase_acc;
    case (s1.op)
      OP_SAMPLE: begin
        if (!s1.above) phase_acc_next = phase_acc + s1.inc;
      end
      OP_SET_PHASE: phase_acc_next = s1.phase_value;
      default:      phase_acc_next = phase_acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (adv1) begin
      phase_acc <= phase_acc_next;
    end
  end

  // Second stage control, alongside the table read
  always_ff @(posedge clk) begin
    if (en2) begin
      ctl2.live      <= live1;
      ctl2.above     <= (s1.op == OP_SAMPLE) && s1.above;
      ctl2.phase_now <= phase_acc_next;
      frac2          <= phase_acc[FRAC_W-1:0];
    end
  end

  // Drop writes outside the table
  assign band_ok = int'(s1.band_index) < NUM_BANDS;
  assign samp_ok = int'(s1.sample_index) < TABLE_SIZE;
  assign rd_en   = adv1 && live1;
  assign wr_en   = adv1 && (s1.op == OP_WRITE) && band_ok && samp_ok;

  wto_table u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (phase_acc[PHASE_W-1:FRAC_W]),
    .rd_wave (s1.wave),
    .rd_band (s1.band),
    .wr_en   (wr_en),
    .wr_wave (s1.wave),
    .wr_band (s1.band_index),
    .wr_idx  (IDX_W'(s1.sample_index)),
    .wr_data (s1.table_value),
    .v0      (tv0),
    .v1      (tv1)
  );

  wto_interp u_interp (
    .clk         (clk),
    .en3         (en3),
    .en4         (en4),
    .en_out      (en_out),
    .v0          (tv0),
    .v1          (tv1),
    .frac2       (frac2),
    .ctl2        (ctl2),
    .sample_out  (sample_out),
    .above_range (above_range),
    .phase_now   (phase_now)
  );

  // Phase moves only when a transaction leaves the first stage
  `WTO_ASSERT(a_phase_hold, clk, rst, !adv1 |=> $stable(phase_acc))
  // One table access per cycle: never read and write together
  `WTO_ASSERT(a_rw_excl, clk, rst, !(rd_en && wr_en))
  // Input stalls when every stage is full behind a stalled result
  `WTO_ASSERT(a_full_stall, clk, rst,
    result_valid && result_stall && v1 && v2 && v3 && v4 |-> item_stall)
  // An out-of-range result carries a zero sample
  `WTO_ASSERT(a_above_zero, clk, rst, result_valid && above_range |-> sample_out == '0)
  // Reset empties the pipeline
  `WTO_ASSERT_NR(a_reset_empty, clk, rst |=> !result_valid && !v1)

endmodule

// ===== tb/sv/wavetable_oscillator_unit_checker.sv =====
// Checker for the wavetable oscillator: tracks its state and compares every result.
module wavetable_oscillator_unit_checker
  import wto_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  logic [1:0]                 operation,
  input  logic [1:0]                 waveform,
  input  logic [21:0]                frequency,
  input  logic [6:0]                 band_index,
  input  logic [9:0]                 sample_index,
  input  logic signed [23:0]         table_value,
  input  logic [31:0]                phase_value,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic signed [23:0]         sample_out,
  input  logic                       above_range,
  input  logic [31:0]                phase_now,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int          WORDS            = 4 * NUM_BANDS * TABLE_SIZE;
  localparam logic [19:0] STEP_AFTER_RESET = 20'd97392;
  localparam logic [2:0]  STEP_ADDR        = {REG_PHASE_STEP, 2'b00};

  // Note limits in Q8 hertz up to the top note; higher bands repeat the last one
  localparam int unsigned NOTE_Q8 [117] = '{
    4186, 4435, 4699, 4978, 5274, 5588, 5920, 6272, 6645, 7040, 7459, 7902,
    8372, 8870, 9397, 9956, 10548, 11175, 11840, 12544, 13290, 14080, 14917, 15804,
    16744, 17740, 18795, 19912, 21096, 22351, 23680, 25088, 26580, 28160, 29834,
    31609, 33488, 35479, 37589, 39824, 42192, 44701, 47359, 50175, 53159, 56320,
    59669, 63217, 66976, 70959, 75178, 79649, 84385, 89402, 94719, 100351, 106318,
    112640, 119338, 126434, 133952, 141917, 150356, 159297, 168769, 178805, 189437,
    200702, 212636, 225280, 238676, 252868, 267905, 283835, 300713, 318594, 337539,
    357610, 378874, 401403, 425272, 450560, 477352, 505736, 535809, 567670, 601425,
    637188, 675077, 715219, 757749, 802807, 850544, 901120, 954703, 1011473,
    1071618, 1135340, 1202851, 1274376, 1350155, 1430439, 1515497, 1605613,
    1701088, 1802240, 1909407, 2022946, 2143237, 2270680, 2405702, 2548752,
    2700309, 2860878, 3030994, 3211227, 3402176
  };
  localparam int unsigned TOP_NOTE = NOTE_Q8[116];

  typedef struct packed {
    logic signed [23:0] sample;
    logic               above;
    logic [31:0]        phase;
  } osc_out_t;

  logic signed [23:0] wave_words [WORDS];
  logic [31:0]        phase_acc;
  logic [19:0]        step_per_hz;
  osc_out_t           outputs_due [$];
  osc_out_t           want;
  int                 errs = 0;

  // Apply one transaction to the oscillator state and work out its result
  task automatic step_oscillator(input logic [1:0] op, input logic [1:0] w,
                                 input logic [21:0] f, input logic [6:0] bi,
                                 input logic [9:0] si, input logic signed [23:0] tv,
                                 input logic [31:0] pv, output osc_out_t r);
    int          band;
    int          base;
    logic [9:0]  i0;
    logic [9:0]  i1;
    longint      v0;
    longint      v1;
    longint      frac;
    longint      prod;
    logic [41:0] rate_prod;
    r.sample = '0;
    r.above  = 1'b0;
    case (op)
      OP_SAMPLE: begin
        if (f > TOP_NOTE) begin
          // hold the phase above the top note
          r.above = 1'b1;
        end else begin
          band = 0;
          while (band < NUM_BANDS - 1 && NOTE_Q8[band > 116 ? 116 : band] < f)
            band++;
          i0   = phase_acc[31:22];
          i1   = i0 + 10'd1;
          frac = longint'({phase_acc[21:0], 10'b0});
          base = (int'(w) * NUM_BANDS + band) * TABLE_SIZE;
          v0   = longint'(wave_words[base + int'(i0)]);
          v1   = longint'(wave_words[base + int'(i1)]);
          prod = (v1 - v0) * frac;
          r.sample = 24'(v0 + (prod >>> 32));
          rate_prod = {20'b0, f} * {22'b0, step_per_hz};
          phase_acc = phase_acc + rate_prod[39:8];
        end
      end
      OP_WRITE: begin
        if (int'(bi) < NUM_BANDS && int'(si) < TABLE_SIZE)
          wave_words[(int'(w) * NUM_BANDS + int'(bi)) * TABLE_SIZE + int'(si)] = tv;
      end
      OP_SET_PHASE: phase_acc = pv;
      default: ;
    endcase
    r.phase = phase_acc;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase_acc   = '0;
      step_per_hz = STEP_AFTER_RESET;
      outputs_due.delete();
    end else begin
      // compare each result transaction with the oldest one awaited
      if (result_valid && !result_stall) begin
        if (outputs_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, actual %0d/%0b/%08h",
                   $time, sample_out, above_range, phase_now);
        end else begin
          want = outputs_due.pop_front();
          if (sample_out !== want.sample) begin
            errs++;
            $display("%0t: sample_out expected %0d, actual %0d",
                     $time, want.sample, sample_out);
          end
          if (above_range !== want.above) begin
            errs++;
            $display("%0t: above_range expected %0b, actual %0b",
                     $time, want.above, above_range);
          end
          if (phase_now !== want.phase) begin
            errs++;
            $display("%0t: phase_now expected %08h, actual %08h",
                     $time, want.phase, phase_now);
          end
        end
      end
      if (item_valid && !item_stall) begin
        step_oscillator(operation, waveform, frequency, band_index, sample_index,
                        table_value, phase_value, want);
        outputs_due.push_back(want);
      end
      // track register writes and check read-back
      if (psel && penable && pready && paddr == STEP_ADDR) begin
        if (pwrite) begin
          step_per_hz = pwdata[19:0];
        end else if (prdata !== 32'(step_per_hz)) begin
          errs++;
          $display("%0t: phase_step_per_hz expected %0d, actual %0d",
                   $time, step_per_hz, prdata);
        end
      end
    end
    mismatches  <= errs;
    outstanding <= outputs_due.size();
  end

endmodule

// ===== tb/sv/wavetable_oscillator_unit_tb.sv =====
// Testbench top for the wavetable oscillator: stimulus, handshake pressure and verdict.
module wavetable_oscillator_unit_tb;
  import wto_pkg::*;

  localparam int WORDS          = 4 * NUM_BANDS * TABLE_SIZE;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int NUM_PHASES     = 6;
  localparam int TOP_NOTE_BAND  = 116;

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic [1:0]         operation;
  logic [1:0]         waveform;
  logic [21:0]        frequency;
  logic [6:0]         band_index;
  logic [9:0]         sample_index;
  logic signed [23:0] table_value;
  logic [31:0]        phase_value;
  logic               result_valid;
  logic               result_stall;
  logic signed [23:0] sample_out;
  logic               above_range;
  logic [31:0]        phase_now;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding;

  bit          loaded [WORDS];
  bit          calm;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  int          samples_sent = 0;
  int          above_sent = 0;
  int          step_settings = 1;
  logic [19:0] step_plan [NUM_PHASES];
  logic [31:0] phase_mirror;
  logic [19:0] step_now;

  wavetable_oscillator_unit dut (.*);
  wavetable_oscillator_unit_checker chk (.*);

  always #5 clk = ~clk;

  // Stall the result channel in random bursts, none once calm
  initial begin
    result_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (!calm) begin
        result_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        result_stall = 1'b0;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int word_at(input int w, input int b, input int i);
    return (w * NUM_BANDS + b) * TABLE_SIZE + i;
  endfunction

  // Band that a frequency at or below the top note selects
  function automatic int band_of(input logic [21:0] f);
    int b;
    b = 0;
    while (b < NUM_BANDS - 1 && BAND_LIMITS[b] < int'(f)) b++;
    return b;
  endfunction

  // Random table word, full-scale values now and then
  function automatic logic [23:0] table_word();
    case ($urandom_range(0, 7))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Frequency that selects band b: either edge or anywhere inside
  function automatic logic [21:0] freq_in_band(input int b);
    int lo;
    int hi;
    lo = (b == 0) ? 0 : BAND_LIMITS[b - 1] + 1;
    hi = BAND_LIMITS[b];
    case ($urandom_range(0, 3))
      0:       return 22'(lo);
      1:       return 22'(hi);
      default: return 22'($urandom_range(hi, lo));
    endcase
  endfunction

  // Drive one transaction, hold it until taken, then maybe pause
  task automatic send_item(input logic [1:0] op, input logic [1:0] w, input logic [21:0] f,
                           input logic [6:0] bi, input logic [9:0] si,
                           input logic [23:0] tv, input logic [31:0] pv);
    @(negedge clk);
    item_valid   = 1'b1;
    operation    = op;
    waveform     = w;
    frequency    = f;
    band_index   = bi;
    sample_index = si;
    table_value  = tv;
    phase_value  = pv;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
  endtask

  task automatic write_word(input int w, input int b, input int i, input logic [23:0] v);
    send_item(OP_WRITE, 2'(w), 22'($urandom), 7'(b), 10'(i), v, $urandom);
    if (b < NUM_BANDS) loaded[word_at(w, b, i)] = 1'b1;
  endtask

  // Load the word pair the current phase reads, then ask for a sample
  task automatic sample_at(input int w, input logic [21:0] f);
    int          b;
    int          k;
    int          k1;
    logic [41:0] rate_prod;
    if (f <= TOP_LIMIT) begin
      b  = band_of(f);
      k  = int'(phase_mirror[31:22]);
      k1 = (k + 1) % TABLE_SIZE;
      if (!loaded[word_at(w, b, k)]) write_word(w, b, k, table_word());
      if (!loaded[word_at(w, b, k1)]) write_word(w, b, k1, table_word());
    end
    send_item(OP_SAMPLE, 2'(w), f, 7'($urandom), 10'($urandom), 24'($urandom), $urandom);
    samples_sent++;
    if (f > TOP_LIMIT) begin
      above_sent++;
    end else begin
      // advance the phase as the block does
      rate_prod    = {20'b0, f} * {22'b0, step_now};
      phase_mirror = phase_mirror + rate_prod[39:8];
    end
  endtask

  task automatic set_phase(input logic [31:0] p);
    send_item(OP_SET_PHASE, 2'($urandom), 22'($urandom), 7'($urandom), 10'($urandom),
              24'($urandom), p);
    phase_mirror = p;
  endtask

  // Load a word pair if needed, point the phase at it and read it back
  task automatic sparse_sample(input int w, input int b);
    int          k;
    int          k1;
    logic [21:0] frac;
    k  = $urandom_range(0, TABLE_SIZE - 1);
    k1 = (k + 1) % TABLE_SIZE;
    if (!loaded[word_at(w, b, k)]) write_word(w, b, k, table_word());
    if (!loaded[word_at(w, b, k1)]) write_word(w, b, k1, table_word());
    case ($urandom_range(0, 3))
      0:       frac = '0;
      1:       frac = '1;
      default: frac = 22'($urandom);
    endcase
    set_phase({10'(k), frac});
    sample_at(w, freq_in_band(b));
  endtask

  // One APB transfer to the step register
  task automatic apb_access(input logic wr, input logic [19:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {REG_PHASE_STEP, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) step_now = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Drop valid and wait until every awaited result has come back
  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int          quota;
    int          pick;
    int          w;
    int          b;
    logic [21:0] f;
    rst          = 1'b1;
    calm         = 1'b0;
    item_valid   = 1'b0;
    operation    = OP_SAMPLE;
    waveform     = '0;
    frequency    = '0;
    band_index   = '0;
    sample_index = '0;
    table_value  = '0;
    phase_value  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    phase_mirror = '0;
    step_now     = STEP_RESET;
    step_plan    = '{20'd97392, 20'd0, 20'hFFFFF, 20'($urandom), 20'd1, 20'($urandom)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    apb_access(1'b0, '0);

    // Zero frequency at phase zero
    sample_at(0, 22'd0);
    // Exactly the top note, with the phase and the table index both wrapping
    set_phase(32'hFFFF_FFFF);
    sample_at(3, TOP_LIMIT);
    // Just above the top note and the largest frequency
    sample_at(1, TOP_LIMIT + 22'd1);
    sample_at(2, 22'h3FFFFF);
    // Full-scale drop across the table end, largest fraction, band upper edge
    write_word(1, 7, TABLE_SIZE - 1, 24'h7FFFFF);
    write_word(1, 7, 0, 24'h800000);
    set_phase({10'h3FF, 22'h3FFFFF});
    sample_at(1, 22'(BAND_LIMITS[7]));
    set_phase(32'hFFC0_0000);
    sample_at(1, 22'(BAND_LIMITS[7]));
    // Full-scale rise at half fraction, band lower edge
    write_word(2, 50, 10, 24'h800000);
    write_word(2, 50, 11, 24'h7FFFFF);
    set_phase({10'd10, 22'h200000});
    sample_at(2, 22'(BAND_LIMITS[49] + 1));
    // Unreachable extra band, out-of-range band, unused operation
    write_word(0, NUM_BANDS - 1, 5, table_word());
    write_word(3, 127, TABLE_SIZE - 1, table_word());
    send_item(OP_IDLE, 2'b11, 22'h3FFFFF, 7'h7F, 10'h3FF, 24'hFFFFFF, 32'hFFFF_FFFF);
    set_phase(32'd0);

    // Random traffic over several step settings, last one with no pauses or result stalls
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        apb_access(1'b1, step_plan[ph]);
        apb_access(1'b0, '0);
        step_settings++;
      end
      calm  = (ph == NUM_PHASES - 1);
      quota = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < quota) begin
        pick = $urandom_range(0, 99);
        w    = $urandom_range(0, 3);
        if (pick < 30) begin
          sample_at(w, freq_in_band($urandom_range(0, 1) ? TOP_NOTE_BAND : 0));
        end else if (pick < 35) begin
          sample_at(w, 22'($urandom_range(22'h3FFFFF, int'(TOP_LIMIT) + 1)));
        end else if (pick < 60) begin
          sparse_sample(w, $urandom_range(0, TOP_NOTE_BAND));
        end else if (pick < 72) begin
          write_word(w, $urandom_range(0, 127), $urandom_range(0, TABLE_SIZE - 1),
                     table_word());
        end else if (pick < 80) begin
          set_phase($urandom);
        end else if (pick < 85) begin
          send_item(OP_IDLE, 2'(w), 22'($urandom), 7'($urandom), 10'($urandom),
                    24'($urandom), $urandom);
        end else begin
          // hold one note for a run to let the phase build up
          b = $urandom_range(0, 1) ? TOP_NOTE_BAND : 0;
          f = freq_in_band(b);
          repeat ($urandom_range(4, 16)) sample_at(w, f);
        end
      end
    end

    drain();
    $display("run: %0d transactions, %0d sample requests (%0d above the top note),",
             items_sent, samples_sent, above_sent);
    $display("run: %0d step settings; band edges, table end wrap, phase wrap and %s",
             step_settings, "full-scale word pairs exercised");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/wto_pkg.sv
src/wto_front.sv
src/wto_table.sv
src/wto_interp.sv
src/wavetable_oscillator_unit.sv
tb/sv/wavetable_oscillator_unit_checker.sv
tb/sv/wavetable_oscillator_unit_tb.sv
